// ===== src/ght_pkg.sv =====
`timescale 1ns / 1ps

package ght_pkg;

   // Field widths of a handle and a slot record
   localparam int GEN_W           = 32;
   localparam int SLOT_FIELD_W    = 16;
   localparam int HANDLE_W        = GEN_W + SLOT_FIELD_W;
   localparam int DEFAULT_ENTRIES = 16;

   // Generation value at which a slot is retired for good
   localparam logic [GEN_W-1:0] GEN_RETIRED = {GEN_W{1'b1}};

   // Request modes
   localparam logic [1:0] MODE_CREATE = 2'd0;
   localparam logic [1:0] MODE_CHECK  = 2'd1;
   localparam logic [1:0] MODE_DELETE = 2'd2;

   // Response status codes
   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_ERROR = 1'b1;

   typedef struct packed {
      logic [1:0]          mode;
      logic [3:0]          entry_kind;
      logic [63:0]         entry_size;
      logic [63:0]         now_ticks;
      logic [HANDLE_W-1:0] handle_in;
   } ght_req_type;

   typedef struct packed {
      logic                status;
      logic [HANDLE_W-1:0] handle_out;
   } ght_rsp_type;

   // Per-slot record in the generation memory
   typedef struct packed {
      logic             in_use;
      logic [GEN_W-1:0] gen;
   } ght_slot_type;

   // Per-slot payload, written on create
   typedef struct packed {
      logic [3:0]  kind;
      logic [63:0] size;
      logic [63:0] timestamp;
   } ght_payload_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DISPATCH,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_LOOK_RD,
      ST_LOOK_CHK,
      ST_FINISH
   } ght_state_type;

endpackage

// ===== src/ght_ram.sv =====
`timescale 1ns / 1ps

module ght_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one word, read one word into the output register
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/generational_handle_table.sv =====
// Check or delete: the slot record named by a well-formed handle is read and
// checked, then the result is registered. Create: slots are scanned one at a
// time through the generation memory read port, each read then checked, until
// a free slot is found (at most ENTRIES visited). One request is in flight at a time.
// Reset (synchronous, active high) starts a clearing pass that zeroes each slot
// record of the generation memory in turn; no request is accepted until it ends.
`timescale 1ns / 1ps

module generational_handle_table #(
   parameter int ENTRIES = ght_pkg::DEFAULT_ENTRIES
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  ght_pkg::ght_req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output ght_pkg::ght_rsp_type rsp_data
);

   import ght_pkg::*;

   localparam int SLOT_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam logic [SLOT_W-1:0]       LAST_SLOT     = SLOT_W'(ENTRIES - 1);
   localparam logic [SLOT_FIELD_W-1:0] ENTRIES_FIELD = SLOT_FIELD_W'(ENTRIES);
   localparam int SLOT_REC_W = $bits(ght_slot_type);
   localparam int PAYLOAD_W  = $bits(ght_payload_type);

   ght_state_type         state_ff, state_in;
   logic [SLOT_W-1:0]     idx_ff, idx_in;
   ght_req_type           req_ff, req_in;
   logic                  pend_status_ff, pend_status_in;
   logic [HANDLE_W-1:0]   pend_handle_ff, pend_handle_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   ght_rsp_type           rsp_data_ff, rsp_data_in;

   logic                  gen_wr_en;
   logic [SLOT_W-1:0]     gen_wr_addr;
   ght_slot_type          gen_wr_rec;
   logic                  gen_rd_en;
   logic [SLOT_W-1:0]     gen_rd_addr;
   logic [SLOT_REC_W-1:0] gen_rd_data;
   logic                  pay_wr_en;
   ght_payload_type       pay_wr_rec;

   logic [SLOT_FIELD_W-1:0] slot_field;
   logic [GEN_W-1:0]        gen_field;
   logic                    handle_bad;
   logic [SLOT_W-1:0]       look_idx;
   ght_slot_type            slot_rd;
   logic                    free_hit;
   logic                    look_hit;
   logic [GEN_W-1:0]        next_gen;
   logic [HANDLE_W-1:0]     new_handle;
   logic                    rsp_load;
   logic                    idx_last;

   // Split the stored handle and evaluate the slot record just read
   always_comb begin
      slot_field = req_ff.handle_in[SLOT_FIELD_W-1:0];
      gen_field  = req_ff.handle_in[HANDLE_W-1:SLOT_FIELD_W];
      handle_bad = (slot_field == '0) || (slot_field > ENTRIES_FIELD) ||
                   (gen_field == '0);
      look_idx   = SLOT_W'(slot_field - SLOT_FIELD_W'(1));
      slot_rd    = ght_slot_type'(gen_rd_data);
      free_hit   = !slot_rd.in_use && (slot_rd.gen != GEN_RETIRED);
      look_hit   = slot_rd.in_use && (slot_rd.gen == gen_field);
      next_gen   = slot_rd.gen + GEN_W'(1);
      new_handle = {next_gen, SLOT_FIELD_W'(idx_ff) + SLOT_FIELD_W'(1)};
      rsp_load   = !rsp_valid_ff || rsp_ready;
      idx_last   = (idx_ff == LAST_SLOT);
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (idx_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = ST_DISPATCH;
         end
         ST_DISPATCH: begin
            if (req_ff.mode == MODE_CREATE) begin
               state_in = ST_SCAN_RD;
            end else if ((req_ff.mode == MODE_CHECK || req_ff.mode == MODE_DELETE) &&
                         !handle_bad) begin
               state_in = ST_LOOK_RD;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_SCAN_RD: begin
            state_in = ST_SCAN_CHK;
         end
         ST_SCAN_CHK: begin
            if (free_hit || idx_last) state_in = ST_FINISH;
            else                      state_in = ST_SCAN_RD;
         end
         ST_LOOK_RD: begin
            state_in = ST_LOOK_CHK;
         end
         ST_LOOK_CHK: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (rsp_load) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // Memory controls and register updates
   always_comb begin
      idx_in         = idx_ff;
      req_in         = req_ff;
      pend_status_in = pend_status_ff;
      pend_handle_in = pend_handle_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_data_in    = rsp_data_ff;
      gen_wr_en      = 1'b0;
      gen_wr_addr    = idx_ff;
      gen_wr_rec     = '0;
      gen_rd_en      = 1'b0;
      gen_rd_addr    = idx_ff;
      pay_wr_en      = 1'b0;
      pay_wr_rec     = '{kind: req_ff.entry_kind, size: req_ff.entry_size,
                         timestamp: req_ff.now_ticks};
      unique case (state_ff)
         ST_CLEAR: begin
            // Zero one slot record per cycle
            gen_wr_en = 1'b1;
            idx_in    = idx_last ? '0 : idx_ff + SLOT_W'(1);
         end
         ST_IDLE: begin
            if (req_valid) req_in = req_data;
         end
         ST_DISPATCH: begin
            idx_in         = '0;
            pend_status_in = STATUS_ERROR;
            pend_handle_in = '0;
         end
         ST_SCAN_RD: begin
            gen_rd_en = 1'b1;
         end
         ST_SCAN_CHK: begin
            if (free_hit) begin
               // Claim the slot under its next generation
               gen_wr_en      = 1'b1;
               gen_wr_rec     = '{in_use: 1'b1, gen: next_gen};
               pay_wr_en      = 1'b1;
               pend_status_in = STATUS_OK;
               pend_handle_in = new_handle;
            end else if (!idx_last) begin
               idx_in = idx_ff + SLOT_W'(1);
            end
         end
         ST_LOOK_RD: begin
            gen_rd_en   = 1'b1;
            gen_rd_addr = look_idx;
         end
         ST_LOOK_CHK: begin
            if (look_hit) begin
               pend_status_in = STATUS_OK;
               if (req_ff.mode == MODE_DELETE) begin
                  // Free the slot, keep its generation
                  gen_wr_en   = 1'b1;
                  gen_wr_addr = look_idx;
                  gen_wr_rec  = '{in_use: 1'b0, gen: slot_rd.gen};
               end
            end
         end
         ST_FINISH: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{status: pend_status_ff, handle_out: pend_handle_ff};
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      req_ff         <= req_in;
      pend_status_ff <= pend_status_in;
      pend_handle_ff <= pend_handle_in;
      rsp_data_ff    <= rsp_data_in;
   end

   // Generation and in-use flag per slot
   ght_ram #(
      .WIDTH (SLOT_REC_W),
      .DEPTH (ENTRIES)
   ) u_gen_ram (
      .clock   (clock),
      .wr_en   (gen_wr_en),
      .wr_addr (gen_wr_addr),
      .wr_data (gen_wr_rec),
      .rd_en   (gen_rd_en),
      .rd_addr (gen_rd_addr),
      .rd_data (gen_rd_data)
   );

   // Kind, size and timestamp per slot
   ght_ram #(
      .WIDTH (PAYLOAD_W),
      .DEPTH (ENTRIES)
   ) u_payload_ram (
      .clock   (clock),
      .wr_en   (pay_wr_en),
      .wr_addr (idx_ff),
      .wr_data (pay_wr_rec),
      .rd_en   (1'b0),
      .rd_addr ('0),
      .rd_data ()
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== src/ght_checker.sv =====
`timescale 1ns / 1ps

module ght_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input ght_pkg::ght_rsp_type rsp_data
);

   import ght_pkg::*;

   // Hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // Error responses carry no handle
   a_err_no_handle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == STATUS_ERROR |-> rsp_data.handle_out == '0)
      else $error("error response with nonzero handle");

   // Successful creates name a real slot and a nonzero generation
   a_ok_handle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == STATUS_OK && rsp_data.handle_out != '0 |->
      rsp_data.handle_out[SLOT_FIELD_W-1:0] != '0 &&
      rsp_data.handle_out[HANDLE_W-1:SLOT_FIELD_W] != '0)
      else $error("handle with zero slot or generation");

   // Drop ready after a request transaction
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while busy");

   // Hold off both channels right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !req_ready && !rsp_valid)
      else $error("channel active after reset");

endmodule

bind generational_handle_table ght_checker u_ght_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
